>>> hw/rtl/dpr_pkg.sv
// ----------------------------------------------------------------------------
// dpr_pkg
// Shared widths and types for the DMA page run coalescer: the segment
// record and the bundle that pushes up to two segments into the queue.
// ----------------------------------------------------------------------------
package dpr_pkg;

    localparam int FRAME_W  = 36;
    localparam int OFFS_W   = 12;
    localparam int ADDR_W   = 48;
    localparam int LEN_W    = 25;

    // Result queue: room for two segments per item plus slack
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [LEN_W-1:0]  length;
        logic              last;
    } seg_t;

    typedef struct packed {
        logic [1:0] count;   // segments in this push: 0, 1 or 2
        seg_t       seg0;
        seg_t       seg1;
    } seg_push_t;

endpackage

>>> hw/rtl/dpr_seg_queue.sv
// ----------------------------------------------------------------------------
// dpr_seg_queue
// Small segment queue with a two-entry write port and a single read port.
// Reports whether two free entries remain so a whole item can be taken.
// ----------------------------------------------------------------------------
module dpr_seg_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dpr_pkg::seg_push_t    push,
    output logic                  room_two,
    output logic                  out_valid,
    input  logic                  out_stall,
    output dpr_pkg::seg_t         head
);

    dpr_pkg::seg_t                  mem [dpr_pkg::QUEUE_DEPTH];
    logic [dpr_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [dpr_pkg::QPTR_W-1:0]     wr_ptr_next;
    logic [dpr_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [dpr_pkg::QPTR_W-1:0]     rd_ptr_next;
    logic [dpr_pkg::QCNT_W-1:0]     count_reg;
    logic [dpr_pkg::QCNT_W-1:0]     count_next;
    logic                           pop;

    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign head      = mem[rd_ptr_reg];
    assign room_two  = (count_reg <= dpr_pkg::QCNT_W'(dpr_pkg::QUEUE_DEPTH - 2));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + dpr_pkg::QPTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + dpr_pkg::QPTR_W'(pop);
        count_next  = count_reg + dpr_pkg::QCNT_W'(push.count) - dpr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.seg0;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_reg + dpr_pkg::QPTR_W'(1)] <= push.seg1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dpr_pkg::QCNT_W'(dpr_pkg::QUEUE_DEPTH))
        else $error("segment queue overfilled");

    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count != 2'd0) |-> room_two)
        else $error("push without two free entries");

    a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && push.count == 2'd0) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count lost track of a pop");

endmodule

>>> hw/rtl/dma_page_run_coalescer.sv
// ----------------------------------------------------------------------------
// dma_page_run_coalescer
// Merges runs of consecutive page frames into scatter-gather segments.
// ----------------------------------------------------------------------------
// One page frame is taken per clock. A page is captured in an input register,
// and in the next cycle a compare, add and clamp against the open segment
// updates the run state and pushes zero, one or two segments into a
// four-entry result queue, and segments are presented at the output from
// the head of that queue. The input stalls only while the page in the
// input register cannot be processed because the queue has fewer than two
// free entries, so a steady one page per cycle is kept as long as segments
// are drained at the rate they are produced. A first page while a run is
// open closes that run as a truncated final segment before starting anew.
module dma_page_run_coalescer
#(
    parameter int PAGE_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [dpr_pkg::FRAME_W-1:0]  page_frame,
    input  logic                         first_page,
    input  logic [dpr_pkg::OFFS_W-1:0]   start_offset,
    input  logic [dpr_pkg::LEN_W-1:0]    total_length,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [dpr_pkg::ADDR_W-1:0]   seg_address,
    output logic [dpr_pkg::LEN_W-1:0]    seg_length,
    output logic                         last_segment
);

    localparam int unsigned PageBytes = 1 << PAGE_BITS;
    localparam int          BaseW     = dpr_pkg::FRAME_W + PAGE_BITS;

    localparam logic [dpr_pkg::LEN_W-1:0] PageLen  = dpr_pkg::LEN_W'(PageBytes);
    localparam logic [dpr_pkg::LEN_W-1:0] OffsMask = dpr_pkg::LEN_W'(PageBytes - 1);

    // input register
    logic                         item_valid_reg;
    logic [dpr_pkg::FRAME_W-1:0]  frame_reg;
    logic                         first_reg;
    logic [dpr_pkg::OFFS_W-1:0]   offset_reg;
    logic [dpr_pkg::LEN_W-1:0]    total_reg;

    // run state
    logic [dpr_pkg::FRAME_W-1:0]  prev_frame_reg, prev_frame_next;
    logic [dpr_pkg::ADDR_W-1:0]   open_address_reg, open_address_next;
    logic [dpr_pkg::LEN_W-1:0]    open_length_reg, open_length_next;
    logic [dpr_pkg::LEN_W-1:0]    bytes_left_reg, bytes_left_next;
    logic                         seg_open_reg, seg_open_next;

    logic                         room_two;
    logic                         advance;
    dpr_pkg::seg_push_t           push;
    dpr_pkg::seg_t                head;

    logic [BaseW-1:0]             base_full;
    logic [dpr_pkg::ADDR_W-1:0]   base_addr;
    logic [dpr_pkg::LEN_W-1:0]    offset;
    logic [dpr_pkg::LEN_W-1:0]    first_len;
    logic [dpr_pkg::LEN_W:0]      grown;
    logic [dpr_pkg::LEN_W-1:0]    left_after;
    logic                         contiguous;

    assign in_stall = item_valid_reg && !room_two;
    assign advance  = item_valid_reg && room_two;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            frame_reg  <= page_frame;
            first_reg  <= first_page;
            offset_reg <= start_offset;
            total_reg  <= total_length;
        end
    end

    always_comb
    begin
        base_full  = {frame_reg, {PAGE_BITS{1'b0}}};
        base_addr  = dpr_pkg::ADDR_W'(base_full);
        offset     = dpr_pkg::LEN_W'(offset_reg) & OffsMask;
        first_len  = PageLen - offset;
        grown      = {1'b0, open_length_reg} + {1'b0, PageLen};
        left_after = bytes_left_reg - open_length_reg;
        contiguous = (prev_frame_reg != '1)
                  && (frame_reg == prev_frame_reg + dpr_pkg::FRAME_W'(1));
    end

    always_comb
    begin
        prev_frame_next   = prev_frame_reg;
        open_address_next = open_address_reg;
        open_length_next  = open_length_reg;
        bytes_left_next   = bytes_left_reg;
        seg_open_next     = seg_open_reg;
        push              = '0;

        if (advance)
        begin
            if (first_reg)
            begin
                // close any truncated run, then start the new transfer
                if (seg_open_reg)
                begin
                    push.count = 2'd1;
                    push.seg0  = '{open_address_reg, open_length_reg, 1'b1};
                end
                seg_open_next     = 1'b0;
                open_address_next = '0;
                open_length_next  = '0;
                bytes_left_next   = total_reg;
                if (total_reg != '0)
                begin
                    if (first_len >= total_reg)
                    begin
                        if (seg_open_reg)
                        begin
                            push.count = 2'd2;
                            push.seg1  = '{base_addr + dpr_pkg::ADDR_W'(offset), total_reg, 1'b1};
                        end
                        else
                        begin
                            push.count = 2'd1;
                            push.seg0  = '{base_addr + dpr_pkg::ADDR_W'(offset), total_reg, 1'b1};
                        end
                        bytes_left_next = '0;
                    end
                    else
                    begin
                        open_address_next = base_addr + dpr_pkg::ADDR_W'(offset);
                        open_length_next  = first_len;
                        prev_frame_next   = frame_reg;
                        seg_open_next     = 1'b1;
                    end
                end
            end
            else if (seg_open_reg)
            begin
                if (contiguous)
                begin
                    if (grown >= {1'b0, bytes_left_reg})
                    begin
                        push.count        = 2'd1;
                        push.seg0         = '{open_address_reg, bytes_left_reg, 1'b1};
                        bytes_left_next   = '0;
                        seg_open_next     = 1'b0;
                        open_address_next = '0;
                        open_length_next  = '0;
                    end
                    else
                    begin
                        open_length_next = dpr_pkg::LEN_W'(grown);
                        prev_frame_next  = frame_reg;
                    end
                end
                else
                begin
                    // run broken: emit it, open a new run at this page or finish the transfer there
                    push.count = 2'd1;
                    push.seg0  = '{open_address_reg, open_length_reg, 1'b0};
                    if (PageLen >= left_after)
                    begin
                        push.count        = 2'd2;
                        push.seg1         = '{base_addr, left_after, 1'b1};
                        bytes_left_next   = '0;
                        seg_open_next     = 1'b0;
                        open_address_next = '0;
                        open_length_next  = '0;
                    end
                    else
                    begin
                        bytes_left_next   = left_after;
                        open_address_next = base_addr;
                        open_length_next  = PageLen;
                        prev_frame_next   = frame_reg;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_frame_reg   <= '0;
            open_address_reg <= '0;
            open_length_reg  <= '0;
            bytes_left_reg   <= '0;
            seg_open_reg     <= 1'b0;
        end
        else
        begin
            prev_frame_reg   <= prev_frame_next;
            open_address_reg <= open_address_next;
            open_length_reg  <= open_length_next;
            bytes_left_reg   <= bytes_left_next;
            seg_open_reg     <= seg_open_next;
        end
    end

    dpr_seg_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room_two  (room_two),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign seg_address  = head.address;
    assign seg_length   = head.length;
    assign last_segment = head.last;

    a_open_short: assert property (@(posedge clk) disable iff (!rst_n)
        seg_open_reg |-> (open_length_reg < bytes_left_reg))
        else $error("open run already covers the remaining bytes");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !first_reg && push.count != 2'd0 &&
         ((push.count == 2'd1 && push.seg0.last) || push.count == 2'd2 && push.seg1.last))
        |=> !seg_open_reg)
        else $error("final segment emitted but run left open");

    a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !room_two) |=> (item_valid_reg && $stable(frame_reg)))
        else $error("held page lost while queue was full");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && first_reg && total_reg == '0) |=> !seg_open_reg)
        else $error("zero-length transfer left a run open");

endmodule

>>> tb/sv/dpr_checker.sv
// ----------------------------------------------------------------------------
// dpr_checker
// Watches both channels of the page run coalescer. It works out the segments
// that each accepted page must produce and compares every segment that leaves
// the block against the oldest one still due.
// ----------------------------------------------------------------------------
module dpr_checker
#(
    parameter int PAGE_BITS = 12
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [dpr_pkg::FRAME_W-1:0]  page_frame,
    input  logic                         first_page,
    input  logic [dpr_pkg::OFFS_W-1:0]   start_offset,
    input  logic [dpr_pkg::LEN_W-1:0]    total_length,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [dpr_pkg::ADDR_W-1:0]   seg_address,
    input  logic [dpr_pkg::LEN_W-1:0]    seg_length,
    input  logic                         last_segment,
    output int                           mismatch_count,
    output int                           segments_pending,
    output int                           segments_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0]                 PAGE_BYTES = 64'd1 << PAGE_BITS;
    localparam logic [dpr_pkg::FRAME_W-1:0] TOP_FRAME  = '1;

    logic [dpr_pkg::FRAME_W-1:0] run_frame;
    logic [dpr_pkg::ADDR_W-1:0]  run_address;
    logic [dpr_pkg::LEN_W-1:0]   run_length;
    logic [dpr_pkg::LEN_W-1:0]   bytes_left;
    logic                        run_open;
    dpr_pkg::seg_t               due_segments[$];
    int                          errors;
    int                          checked;

    function automatic logic [63:0] widen_len(input logic [dpr_pkg::LEN_W-1:0] v);
        return {{(64-dpr_pkg::LEN_W){1'b0}}, v};
    endfunction

    function automatic logic [63:0] widen_addr(input logic [dpr_pkg::ADDR_W-1:0] v);
        return {{(64-dpr_pkg::ADDR_W){1'b0}}, v};
    endfunction

    task automatic queue_segment(input logic [63:0] address,
                                 input logic [dpr_pkg::LEN_W-1:0] length,
                                 input logic last);
        dpr_pkg::seg_t s;
        s.address = address[dpr_pkg::ADDR_W-1:0];
        s.length  = length;
        s.last    = last;
        due_segments.push_back(s);
    endtask

    task automatic drop_run();
        run_open    = 1'b0;
        run_address = '0;
        run_length  = '0;
    endtask

    // Open a run at this page, or finish the transfer when the page covers the rest
    task automatic open_run(input logic [dpr_pkg::FRAME_W-1:0] frame,
                            input logic [63:0] address,
                            input logic [63:0] length);
        if (length >= widen_len(bytes_left))
        begin
            queue_segment(address, bytes_left, 1'b1);
            bytes_left = '0;
            drop_run();
        end
        else
        begin
            run_address = address[dpr_pkg::ADDR_W-1:0];
            run_length  = length[dpr_pkg::LEN_W-1:0];
            run_frame   = frame;
            run_open    = 1'b1;
        end
    endtask

    task automatic coalesce_page(input logic [dpr_pkg::FRAME_W-1:0] frame,
                                 input logic first,
                                 input logic [dpr_pkg::OFFS_W-1:0] offset,
                                 input logic [dpr_pkg::LEN_W-1:0] total);
        logic [63:0] base;
        logic [63:0] offs;
        logic [63:0] grown;
        base = {{(64-dpr_pkg::FRAME_W){1'b0}}, frame} << PAGE_BITS;
        offs = {{(64-dpr_pkg::OFFS_W){1'b0}}, offset} & (PAGE_BYTES - 64'd1);
        if (first)
        begin
            // a transfer still open is cut short and closed as final
            if (run_open)
                queue_segment(widen_addr(run_address), run_length, 1'b1);
            drop_run();
            bytes_left = total;
            if (total != '0)
                open_run(frame, base + offs, PAGE_BYTES - offs);
        end
        else if (run_open)
        begin
            if (run_frame != TOP_FRAME && frame == run_frame + 1'b1)
            begin
                grown = widen_len(run_length) + PAGE_BYTES;
                if (grown >= widen_len(bytes_left))
                begin
                    queue_segment(widen_addr(run_address), bytes_left, 1'b1);
                    bytes_left = '0;
                    drop_run();
                end
                else
                begin
                    run_length = grown[dpr_pkg::LEN_W-1:0];
                    run_frame  = frame;
                end
            end
            else
            begin
                // run broken: flush it and start again at this page
                queue_segment(widen_addr(run_address), run_length, 1'b0);
                bytes_left = bytes_left - run_length;
                run_open   = 1'b0;
                open_run(frame, base, PAGE_BYTES);
            end
        end
    endtask

    task automatic check_segment();
        dpr_pkg::seg_t want;
        if (due_segments.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("%0t: segment with none due: addr %h len %0d last %0b",
                         $time, seg_address, seg_length, last_segment);
        end
        else
        begin
            want = due_segments.pop_front();
            checked++;
            if (seg_address !== want.address || seg_length !== want.length ||
                last_segment !== want.last)
            begin
                errors++;
                if (errors <= 10)
                    $display({"%0t: segment mismatch: want addr %h len %0d last %0b,",
                              " got addr %h len %0d last %0b"},
                             $time, want.address, want.length, want.last,
                             seg_address, seg_length, last_segment);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drop_run();
            run_frame  = '0;
            bytes_left = '0;
            due_segments.delete();
            errors  = 0;
            checked = 0;
            mismatch_count   <= 0;
            segments_pending <= 0;
            segments_checked <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                coalesce_page(page_frame, first_page, start_offset, total_length);
            if (out_valid && !out_stall)
                check_segment();
            mismatch_count   <= errors;
            segments_pending <= due_segments.size();
            segments_checked <= checked;
        end
    end

endmodule

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives page frames into the page run coalescer and drains its segments,
// with random gaps on both channels and one long hold-off on the output.
// A directed run of transfers comes first, then random transfers.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAGE_BITS  = 12;
    localparam int PAGE_BYTES = 1 << PAGE_BITS;
    localparam int RUN_LIMIT  = 400000;
    localparam int HOLD_OFF   = 300;
    localparam int PHASE_ITEMS = 175;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic [dpr_pkg::FRAME_W-1:0] page_frame = '0;
    logic                        first_page = 1'b0;
    logic [dpr_pkg::OFFS_W-1:0]  start_offset = '0;
    logic [dpr_pkg::LEN_W-1:0]   total_length = '0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic [dpr_pkg::ADDR_W-1:0]  seg_address;
    logic [dpr_pkg::LEN_W-1:0]   seg_length;
    logic                        last_segment;

    int mismatch_count;
    int segments_pending;
    int segments_checked;
    int cycle_count = 0;
    int pages_offered = 0;
    int transfer_pages = 0;
    bit in_calm = 1'b0;
    bit out_calm = 1'b0;
    bit hold_off_req = 1'b0;

    always #4 clk = ~clk;

    dma_page_run_coalescer #(.PAGE_BITS(PAGE_BITS)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .page_frame   (page_frame),
        .first_page   (first_page),
        .start_offset (start_offset),
        .total_length (total_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .seg_address  (seg_address),
        .seg_length   (seg_length),
        .last_segment (last_segment)
    );

    dpr_checker #(.PAGE_BITS(PAGE_BITS)) seg_check
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .page_frame       (page_frame),
        .first_page       (first_page),
        .start_offset     (start_offset),
        .total_length     (total_length),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .seg_address      (seg_address),
        .seg_length       (seg_length),
        .last_segment     (last_segment),
        .mismatch_count   (mismatch_count),
        .segments_pending (segments_pending),
        .segments_checked (segments_checked)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= RUN_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d segments still due",
                     cycle_count, segments_pending);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one page and hold it until the transaction completes
    task automatic offer_page(input logic [dpr_pkg::FRAME_W-1:0] frame,
                              input logic first,
                              input logic [dpr_pkg::OFFS_W-1:0] offset,
                              input logic [dpr_pkg::LEN_W-1:0] total);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        page_frame   <= frame;
        first_page   <= first;
        start_offset <= offset;
        total_length <= total;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pages_offered++;
    endtask

    task automatic random_transfer();
        logic [63:0]                 pick;
        logic [dpr_pkg::FRAME_W-1:0] frame;
        logic [dpr_pkg::OFFS_W-1:0]  offset;
        logic [dpr_pkg::LEN_W-1:0]   total;
        int                          pages;
        pick  = {$urandom, $urandom};
        frame = pick[dpr_pkg::FRAME_W-1:0];
        // now and then start near the top frame so the frames wrap past it
        if ($urandom_range(0, 9) == 0)
        begin
            pick  = {32'd0, $urandom_range(0, 3)};
            frame = '1 - pick[dpr_pkg::FRAME_W-1:0];
        end
        pick   = {$urandom, $urandom};
        offset = pick[dpr_pkg::OFFS_W-1:0];
        pages  = $urandom_range(1, 6);
        case ($urandom_range(0, 11))
            0:       total = '0;
            1:       total = pick[dpr_pkg::LEN_W+31:32];
            2:       total = '1;
            default:
            begin
                pick  = {32'd0, $urandom_range(1, pages * PAGE_BYTES)};
                total = pick[dpr_pkg::LEN_W-1:0];
            end
        endcase
        offer_page(frame, 1'b1, offset, total);
        transfer_pages++;
        for (int i = 1; i < pages && total != '0; i++)
        begin
            case ($urandom_range(0, 9))
                7:       ;
                8:
                begin
                    pick  = {$urandom, $urandom};
                    frame = pick[dpr_pkg::FRAME_W-1:0];
                end
                9:       frame = frame + 2'd2;
                default: frame = frame + 1'b1;
            endcase
            pick = {$urandom, $urandom};
            offer_page(frame, 1'b0, pick[dpr_pkg::OFFS_W-1:0], pick[dpr_pkg::LEN_W+31:32]);
            transfer_pages++;
        end
        // stray page between transfers
        if ($urandom_range(0, 7) == 0)
        begin
            pick = {$urandom, $urandom};
            offer_page(pick[dpr_pkg::FRAME_W-1:0], 1'b0, pick[63:52],
                       pick[dpr_pkg::LEN_W+31:32]);
        end
    endtask

    initial
    begin : drain
        int  wait_cycles;
        bit  hold_done;
        hold_done = 1'b0;
        forever
        begin
            if (hold_off_req && !hold_done)
            begin
                wait_cycles = HOLD_OFF;
                hold_done   = 1'b1;
            end
            else
                wait_cycles = out_calm ? 0 : $urandom_range(0, 19);
            if (wait_cycles > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_cycles) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int target;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero length, then a page with nothing open
        offer_page('0, 1'b1, '0, '0);
        offer_page(36'd5, 1'b0, '1, '1);
        // short transfer inside its first page
        offer_page(36'd10, 1'b1, 12'd100, 25'd50);
        // contiguous run that ends mid-page
        offer_page(36'd20, 1'b1, '0, 25'(2 * PAGE_BYTES + PAGE_BYTES / 2));
        offer_page(36'd21, 1'b0, '0, '0);
        offer_page(36'd22, 1'b0, '0, '0);
        // one byte on the first page, a break, then a truncating new transfer
        offer_page(36'd30, 1'b1, '1, '1);
        offer_page(36'd40, 1'b0, '0, '0);
        offer_page(36'd41, 1'b0, '0, '0);
        offer_page(36'd50, 1'b1, '0, 25'd1);
        // top frame followed by frame zero
        offer_page('1, 1'b1, '0, 25'(4 * PAGE_BYTES));
        offer_page('0, 1'b0, '0, '0);
        offer_page(36'd1, 1'b0, '0, '0);
        offer_page(36'd2, 1'b0, '0, '0);
        // break where the new page finishes the transfer, then a late page
        offer_page(36'd100, 1'b1, '0, 25'(PAGE_BYTES + 7));
        offer_page(36'd200, 1'b0, '0, '0);
        offer_page(36'd201, 1'b0, '1, '1);
        // same frame twice breaks the run
        offer_page(36'd300, 1'b1, 12'd8, 25'(3 * PAGE_BYTES));
        offer_page(36'd300, 1'b0, '0, '0);
        offer_page(36'd301, 1'b0, '0, '0);
        offer_page(36'd302, 1'b0, '0, '0);
        // high address bits and longest length, cut short by the next transfer
        offer_page(36'hA_5A5A_5A5A, 1'b1, 12'h800, '1);
        offer_page(36'h5_A5A5_A5A5, 1'b1, '0, 25'd1);

        // random transfers: both idling, input flat out with a long hold-off,
        // output flat out, then neither idling
        target = transfer_pages;
        for (int phase = 0; phase < 4; phase++)
        begin
            in_calm  = (phase == 1 || phase == 3);
            out_calm = (phase >= 2);
            if (phase == 1)
                hold_off_req = 1'b1;
            target += PHASE_ITEMS;
            while (transfer_pages < target)
                random_transfer();
        end
        in_valid <= 1'b0;
        out_calm = 1'b1;

        do
            @(posedge clk);
        while (segments_pending != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d pages (%0d in transfers), %0d segments compared",
                 pages_offered, transfer_pages, segments_checked);
        $display("idle-free and randomly idling phases on both sides, one long output hold-off");
        if (mismatch_count == 0 && segments_pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> dma_page_run_coalescer.f
hw/rtl/dpr_pkg.sv
hw/rtl/dpr_seg_queue.sv
hw/rtl/dma_page_run_coalescer.sv
tb/sv/dpr_checker.sv
tb/sv/testbench.sv
